### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

### rtl/lecb_pkg.sv
// ----------------------------------------------------------------------------
// lecb_pkg
// shared types and constants of the line editor cursor buffer
// ----------------------------------------------------------------------------
package lecb_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [7:0]        char_t;

    // register word index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_LEFT_KEY  = 2'd0,
        REG_RIGHT_KEY = 2'd1,
        REG_ERASE_KEY = 2'd2
    } reg_idx_t;

    localparam char_t LEFT_KEY_RST  = 8'd60;  // '<'
    localparam char_t RIGHT_KEY_RST = 8'd62;  // '>'
    localparam char_t ERASE_KEY_RST = 8'd45;  // '-'

    typedef enum logic [1:0] {
        KEY_LEFT,
        KEY_RIGHT,
        KEY_ERASE,
        KEY_INSERT
    } key_kind_t;

    typedef struct packed {
        char_t left_code;
        char_t right_code;
        char_t erase_code;
    } cfg_t;

    typedef struct packed {
        logic lc_inc;
        logic lc_dec;
        logic rc_inc;
        logic rc_dec;
        logic wr_left_key;
        logic wr_left_move;
        logic wr_right_move;
        logic rd_left_top;
        logic rd_right_top;
        logic set_ovf;
        logic fp_clr;
        logic fp_inc;
        logic fl_rd;
        logic out_load;
        logic out_empty;
        logic clr_all;
    } dp_cmd_t;

    typedef struct packed {
        key_kind_t kind;
        logic      lc_zero;
        logic      rc_zero;
        logic      lc_full;
        logic      rc_full;
        logic      full;
        logic      empty;
        logic      fl_last;
        logic      out_free;
    } dp_status_t;

endpackage

### rtl/lecb_regs.sv
// ----------------------------------------------------------------------------
// lecb_regs
// apb register file holding the three editing key codes
// ----------------------------------------------------------------------------
module lecb_regs import lecb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_code  <= LEFT_KEY_RST;
            cfg_reg.right_code <= RIGHT_KEY_RST;
            cfg_reg.erase_code <= ERASE_KEY_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_LEFT_KEY:  cfg_reg.left_code  <= pwdata[7:0];
                REG_RIGHT_KEY: cfg_reg.right_code <= pwdata[7:0];
                REG_ERASE_KEY: cfg_reg.erase_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_LEFT_KEY:  prdata[7:0] = cfg_reg.left_code;
            REG_RIGHT_KEY: prdata[7:0] = cfg_reg.right_code;
            REG_ERASE_KEY: prdata[7:0] = cfg_reg.erase_code;
            default:       prdata      = '0;
        endcase
    end

endmodule

### rtl/lecb_ctrl.sv
// ----------------------------------------------------------------------------
// lecb_ctrl
// sequencer for key requests and line flushes
// ----------------------------------------------------------------------------
module lecb_ctrl import lecb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       req_type,
    output logic       s_tready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_FL_RD,
        ST_FL_LD,
        ST_FL_EMPTY
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    logic   accept;

    assign s_tready = ready_reg;
    assign accept   = s_tvalid & ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_type) begin
                        cmd.fp_clr = 1'b1;
                        state_next = sts.empty ? ST_FL_EMPTY : ST_FL_RD;
                    end else begin
                        unique case (sts.kind)
                            KEY_LEFT: begin
                                if (!sts.lc_zero && !sts.rc_full) begin
                                    cmd.rd_left_top = 1'b1;
                                    cmd.lc_dec      = 1'b1;
                                    state_next      = ST_MOVE_L;
                                end
                            end
                            KEY_RIGHT: begin
                                if (!sts.rc_zero && !sts.lc_full) begin
                                    cmd.rd_right_top = 1'b1;
                                    cmd.rc_dec       = 1'b1;
                                    state_next       = ST_MOVE_R;
                                end
                            end
                            KEY_ERASE: begin
                                cmd.lc_dec = !sts.lc_zero;
                            end
                            KEY_INSERT: begin
                                if (!sts.full && !sts.lc_full) begin
                                    cmd.wr_left_key = 1'b1;
                                    cmd.lc_inc      = 1'b1;
                                end else begin
                                    cmd.set_ovf = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_MOVE_L: begin
                cmd.wr_right_move = 1'b1;
                cmd.rc_inc        = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_MOVE_R: begin
                cmd.wr_left_move = 1'b1;
                cmd.lc_inc       = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_FL_RD: begin
                cmd.fl_rd  = 1'b1;
                state_next = ST_FL_LD;
            end
            ST_FL_LD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.fl_last) begin
                        cmd.clr_all = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.fp_inc = 1'b1;
                        state_next = ST_FL_RD;
                    end
                end
            end
            ST_FL_EMPTY: begin
                if (sts.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_empty = 1'b1;
                    cmd.clr_all   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

### rtl/lecb_dp.sv
// ----------------------------------------------------------------------------
// lecb_dp
// two character stacks, their counts and the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lecb_dp import lecb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  char_t      key_byte,
    input  dp_cmd_t    cmd,
    output dp_status_t sts,
    output logic       m_tvalid,
    input  logic       m_tready,
    output char_t      out_char,
    output logic       is_last,
    output logic       empty_line,
    output logic       overflowed
);

    char_t left_mem  [DEPTH];
    char_t right_mem [DEPTH];
    char_t left_rd_reg, right_rd_reg;

    cnt_t lc_reg, lc_next, rc_reg, rc_next, fp_reg, fp_next;
    logic ovf_reg, ovf_next;
    cnt_t total, lc_m1, rc_m1, rev_idx, fp_p1;
    logic fl_left;
    key_kind_t kind_dec;

    char_t out_char_reg;
    logic  last_reg, empty_reg, ovf_out_reg, valid_reg;

    logic  left_we, left_re, right_we, right_re;
    addr_t left_waddr, left_raddr, right_waddr, right_raddr;
    char_t left_wdata;

    assign total   = lc_reg + rc_reg;
    assign lc_m1   = lc_reg - cnt_t'(1);
    assign rc_m1   = rc_reg - cnt_t'(1);
    assign fp_p1   = fp_reg + cnt_t'(1);
    assign rev_idx = total - fp_p1;       // right stack is read top-down
    assign fl_left = fp_reg < lc_reg;

    // key decode, first match wins
    always_comb begin
        priority if (key_byte == cfg.left_code)  kind_dec = KEY_LEFT;
        else if (key_byte == cfg.right_code)     kind_dec = KEY_RIGHT;
        else if (key_byte == cfg.erase_code)     kind_dec = KEY_ERASE;
        else                                     kind_dec = KEY_INSERT;
    end

    assign sts.kind     = kind_dec;
    assign sts.lc_zero  = (lc_reg == '0);
    assign sts.rc_zero  = (rc_reg == '0);
    assign sts.lc_full  = (lc_reg == cnt_t'(DEPTH));
    assign sts.rc_full  = (rc_reg == cnt_t'(DEPTH));
    assign sts.full     = (total == cnt_t'(DEPTH));
    assign sts.empty    = (total == '0);
    assign sts.fl_last  = (fp_p1 == total);
    assign sts.out_free = !valid_reg || m_tready;

    // left stack port
    assign left_we    = cmd.wr_left_key | cmd.wr_left_move;
    assign left_waddr = lc_reg[ADDR_W-1:0];
    assign left_wdata = cmd.wr_left_key ? key_byte : right_rd_reg;
    assign left_re    = cmd.rd_left_top | (cmd.fl_rd & fl_left);
    assign left_raddr = cmd.rd_left_top ? lc_m1[ADDR_W-1:0] : fp_reg[ADDR_W-1:0];

    // right stack port
    assign right_we    = cmd.wr_right_move;
    assign right_waddr = rc_reg[ADDR_W-1:0];
    assign right_re    = cmd.rd_right_top | (cmd.fl_rd & !fl_left);
    assign right_raddr = cmd.rd_right_top ? rc_m1[ADDR_W-1:0] : rev_idx[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (left_we) begin
            left_mem[left_waddr] <= left_wdata;
        end
        if (left_re) begin
            left_rd_reg <= left_mem[left_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (right_we) begin
            right_mem[right_waddr] <= left_rd_reg;
        end
        if (right_re) begin
            right_rd_reg <= right_mem[right_raddr];
        end
    end

    always_comb begin
        lc_next  = lc_reg;
        rc_next  = rc_reg;
        fp_next  = fp_reg;
        ovf_next = ovf_reg | cmd.set_ovf;
        if (cmd.lc_inc) lc_next = lc_reg + cnt_t'(1);
        if (cmd.lc_dec) lc_next = lc_m1;
        if (cmd.rc_inc) rc_next = rc_reg + cnt_t'(1);
        if (cmd.rc_dec) rc_next = rc_m1;
        if (cmd.fp_clr) fp_next = '0;
        if (cmd.fp_inc) fp_next = fp_p1;
        if (cmd.clr_all) begin
            lc_next  = '0;
            rc_next  = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg    <= '0;
            rc_reg    <= '0;
            fp_reg    <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            lc_reg  <= lc_next;
            rc_reg  <= rc_next;
            fp_reg  <= fp_next;
            ovf_reg <= ovf_next;
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_char_reg <= cmd.out_empty ? '0 : (fl_left ? left_rd_reg : right_rd_reg);
            last_reg     <= cmd.out_empty | sts.fl_last;
            empty_reg    <= cmd.out_empty;
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign m_tvalid   = valid_reg;
    assign out_char   = out_char_reg;
    assign is_last    = last_reg;
    assign empty_line = empty_reg;
    assign overflowed = ovf_out_reg;

    `ASSERT_PROP(a_cnt_bound, aclk, aresetn, ({1'b0, lc_reg} + {1'b0, rc_reg}) <= (CNT_W+1)'(DEPTH), "stack counts exceed depth")
    `ASSERT_PROP(a_clr_done, aclk, aresetn, cmd.clr_all |=> (lc_reg == '0 && rc_reg == '0 && !ovf_reg), "flush did not clear buffer")
    `ASSERT_NEVER(a_load_busy, aclk, aresetn, cmd.out_load && valid_reg && !m_tready, "result overwritten while stalled")
    `ASSERT_PROP(a_ovf_full, aclk, aresetn, cmd.set_ovf |-> (sts.full || sts.lc_full), "overflow set below capacity")

endmodule

### rtl/line_editor_cursor_buffer.sv
// ----------------------------------------------------------------------------
// line_editor_cursor_buffer
// keystroke line editor kept as a gap buffer of two character stacks
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one request per handshake: s_tuser[0] = 0 applies the
//   key byte in s_tdata[7:0] (cursor left, cursor right, erase, or insert),
//   s_tuser[0] = 1 flushes the line and clears the buffer
//   m_ channel returns the flushed line left to right, one character per
//   request, m_tlast on the final one; an empty line gives one request with
//   character zero and the empty flag set
//   apb port at byte addresses 0, 4, 8 holds the left, right and erase codes
// steps:
//   insert and erase complete in the idle state; a cursor move does a
//   registered read of one stack, then a write of the other; a flush reads
//   each character from stack memory into a register, then loads it into
//   the result register (an empty line loads a single zero character)
// reset drops the line, clears the overflow flag and restores the default
// key codes; while the receiver stalls the result register holds and the
// flush pauses; the next request is taken as soon as the last result is
// loaded, even if it still waits to be taken
// ----------------------------------------------------------------------------
module line_editor_cursor_buffer import lecb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] key_byte
    input  logic [0:0]        s_tuser,   // [0] req_type
    // result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_char
    output logic              m_tlast,   // is_last
    output logic [1:0]        m_tuser,   // [0] empty_line, [1] overflowed
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t sts;
    logic       empty_line, overflowed;

    // key code registers
    lecb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: decides per request which stack operations run
    lecb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stacks, counts and result register
    lecb_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .key_byte   (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_char   (m_tdata),
        .is_last    (m_tlast),
        .empty_line (empty_line),
        .overflowed (overflowed)
    );

    assign m_tuser = {overflowed, empty_line};

endmodule

### tb/sv/line_editor_cursor_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_editor_cursor_buffer_tb
// self-checking bench for the gap buffer line editor: keystroke and flush
// requests go in on the s_ stream, and a predictor of both character stacks
// computes every flushed character. Results on the m_ stream are compared
// with those predictions in order, and the key codes are changed over apb
// ----------------------------------------------------------------------------
module line_editor_cursor_buffer_tb;
    import lecb_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1000000;

    // one flushed character as the result stream should carry it
    typedef struct {
        char_t ch;
        bit    last;
        bit    empty;
        bit    ovf;
    } line_char_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [7:0] key_byte
    logic [0:0]        s_tuser  = '0;   // [0] req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // [7:0] out_char
    logic              m_tlast;         // is_last
    logic [1:0]        m_tuser;         // [0] empty_line, [1] overflowed
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predictor state: both stacks, their fill levels, sticky overflow, codes
    char_t       left_chars [DEPTH];
    char_t       right_chars[DEPTH];
    int unsigned left_len;
    int unsigned right_len;
    bit          ovf_sticky;
    char_t       code_left;
    char_t       code_right;
    char_t       code_erase;

    // flushed characters still to arrive, oldest first
    line_char_t  line_chars_q[$];
    line_char_t  want;

    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          requests_sent = 0;

    // idling control for the sender and the receiver
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // receiver hold-off: the test bumps hold_seq, the receiver counts it down
    int          hold_seq = 0;
    int          hold_len = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    line_editor_cursor_buffer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // run limit, counted in clock cycles
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("FAIL line_editor_cursor_buffer");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // first match wins in the order left, right, erase
    function automatic key_kind_t classify_key(char_t key);
        if (key == code_left)  return KEY_LEFT;
        if (key == code_right) return KEY_RIGHT;
        if (key == code_erase) return KEY_ERASE;
        return KEY_INSERT;
    endfunction

    function automatic void edit_line(char_t key);
        case (classify_key(key))
            KEY_LEFT: begin
                // no-op at the left edge
                if (left_len > 0 && right_len < DEPTH) begin
                    left_len--;
                    right_chars[right_len] = left_chars[left_len];
                    right_len++;
                end
            end
            KEY_RIGHT: begin
                if (right_len > 0 && left_len < DEPTH) begin
                    right_len--;
                    left_chars[left_len] = right_chars[right_len];
                    left_len++;
                end
            end
            KEY_ERASE: begin
                if (left_len > 0) left_len--;
            end
            default: begin
                // full buffer drops the character and latches overflow
                if (left_len + right_len < DEPTH) begin
                    left_chars[left_len] = key;
                    left_len++;
                end else begin
                    ovf_sticky = 1'b1;
                end
            end
        endcase
    endfunction

    // queue the line left to right, then clear the buffer
    function automatic void flush_line();
        int unsigned total;
        int unsigned n;
        line_char_t  c;
        total = left_len + right_len;
        n = 0;
        c.ovf = ovf_sticky;
        c.empty = 1'b0;
        if (total == 0) begin
            c.ch = '0;
            c.last = 1'b1;
            c.empty = 1'b1;
            line_chars_q.push_back(c);
        end else begin
            for (int unsigned i = 0; i < left_len; i++) begin
                n++;
                c.ch = left_chars[i];
                c.last = (n == total);
                line_chars_q.push_back(c);
            end
            for (int unsigned i = right_len; i > 0; i--) begin
                n++;
                c.ch = right_chars[i-1];
                c.last = (n == total);
                line_chars_q.push_back(c);
            end
        end
        left_len = 0;
        right_len = 0;
        ovf_sticky = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (line_chars_q.size() == 0) begin
                $error("unexpected result: out_char %0h is_last %0b", m_tdata, m_tlast);
                fail_cnt++;
            end else begin
                want = line_chars_q.pop_front();
                if (m_tdata !== want.ch) begin
                    $error("out_char: expected %0h actual %0h", want.ch, m_tdata);
                    fail_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("is_last: expected %0b actual %0b", want.last, m_tlast);
                    fail_cnt++;
                end
                if (m_tuser[0] !== want.empty) begin
                    $error("empty_line: expected %0b actual %0b", want.empty, m_tuser[0]);
                    fail_cnt++;
                end
                if (m_tuser[1] !== want.ovf) begin
                    $error("overflowed: expected %0b actual %0b", want.ovf, m_tuser[1]);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when the test asks for one
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------

    // one request on the s_ stream; valid stays high into the next request
    // unless the sender idles first
    task automatic send_request(bit flush, char_t key);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= flush;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (flush) flush_line();
        else       edit_line(key);
    endtask

    // drop valid and wait for every predicted character to come out
    task automatic pause_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (line_chars_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(reg_idx_t idx, char_t value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW-8){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_LEFT_KEY:  code_left  = value;
            REG_RIGHT_KEY: code_right = value;
            default:       code_erase = value;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // codes change only with the editor idle; cursor moves finish after their
    // request is taken, so give them room
    task automatic write_key_codes(char_t l, char_t r, char_t e);
        pause_until_drained();
        repeat (8) @(posedge aclk);
        apb_write(REG_LEFT_KEY,  l);
        apb_write(REG_RIGHT_KEY, r);
        apb_write(REG_ERASE_KEY, e);
    endtask

    // a byte that is inserted under the current codes
    function automatic char_t pick_text_char();
        char_t c;
        do c = char_t'($urandom_range(0, 255));
        while (c == code_left || c == code_right || c == code_erase);
        return c;
    endfunction

    // one line of mixed keystrokes, then a flush carrying a random key byte
    task automatic send_random_line(int len);
        int    r;
        char_t k;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      k = pick_text_char();
            else if (r < 67) k = code_left;
            else if (r < 79) k = code_right;
            else if (r < 87) k = code_erase;
            else             k = char_t'($urandom_range(0, 255));
            send_request(1'b0, k);
        end
        send_request(1'b1, char_t'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // edge moves, mid-line insert and erase, key byte extremes, empty flush
    task automatic test_directed_edits();
        send_request(1'b1, 8'h00);          // empty line
        send_request(1'b0, code_left);      // left edge
        send_request(1'b0, code_erase);     // erase with nothing before cursor
        send_request(1'b0, code_right);     // right edge
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'h61);
        send_request(1'b0, code_left);
        send_request(1'b0, code_left);
        send_request(1'b0, 8'h62);          // insert in the middle
        send_request(1'b0, code_right);
        send_request(1'b0, code_erase);     // erase in the middle
        send_request(1'b0, code_right);
        send_request(1'b0, code_right);     // right edge with text
        send_request(1'b1, 8'hFF);          // flush ignores its key byte
        send_request(1'b0, 8'h41);
        send_request(1'b1, code_left);
    endtask

    // shared codes: left beats right and erase, right beats erase
    task automatic test_coinciding_codes();
        write_key_codes(8'h00, 8'h00, 8'h00);
        send_request(1'b0, 8'h71);
        send_request(1'b0, 8'h72);
        send_request(1'b0, 8'h00);
        send_request(1'b1, 8'h00);
        write_key_codes(8'hFF, 8'h00, 8'h00);
        send_request(1'b0, 8'h61);
        send_request(1'b0, 8'h62);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'h00);
        send_request(1'b1, 8'h00);
    endtask

    // fill to DEPTH, drop inserts, move at full, flush with overflow set
    task automatic test_full_buffer();
        write_key_codes(LEFT_KEY_RST, RIGHT_KEY_RST, ERASE_KEY_RST);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        for (int i = 0; i < DEPTH; i++) send_request(1'b0, pick_text_char());
        repeat (2) send_request(1'b0, pick_text_char());
        repeat (5) send_request(1'b0, code_left);
        send_request(1'b0, pick_text_char());
        repeat (2) send_request(1'b0, code_right);
        send_request(1'b1, 8'h00);
        send_request(1'b1, 8'h00);          // flag cleared by the flush
        pause_until_drained();
    endtask

    // receiver holds off long enough for the editor to stall its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 300;
        hold_seq++;
        repeat (3) send_random_line(8);
        // sender waits for the whole backlog before going on
        pause_until_drained();
    endtask

    // random lines under each idling mix, new codes every phase
    task automatic test_random_phases();
        int first;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_key_codes(8'h00, 8'hFF, char_t'($urandom_range(1, 254)));
                1: write_key_codes(8'hFF, 8'h00, char_t'($urandom_range(0, 255)));
                default: write_key_codes(char_t'($urandom_range(0, 255)),
                                         char_t'($urandom_range(0, 255)),
                                         char_t'($urandom_range(0, 255)));
            endcase
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            first = requests_sent;
            while (requests_sent - first < 20) begin
                // mostly short lines, now and then one long enough to overflow
                if ($urandom_range(0, 9) == 0) send_random_line($urandom_range(40, 80));
                else                           send_random_line($urandom_range(0, 16));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        left_len   = 0;
        right_len  = 0;
        ovf_sticky = 1'b0;
        code_left  = LEFT_KEY_RST;
        code_right = RIGHT_KEY_RST;
        code_erase = ERASE_KEY_RST;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_edits();
        test_coinciding_codes();
        test_full_buffer();
        test_backpressure();
        test_random_phases();

        pause_until_drained();
        repeat (2 * DEPTH + 16) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("PASS line_editor_cursor_buffer");
        end else begin
            $display("FAIL line_editor_cursor_buffer");
        end
        $finish;
    end

endmodule
